// ----- sv/assert_macros.svh -----
// Assertion macros for the checker file of the DES block.
// No dependencies; take in with `include before the module that asserts.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DES_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error(msg);

// Check that a condition implies another in the same cycle.
`define DES_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
	`DES_ASSERT(label, clk, rst_n, (cond) |-> (expr), msg)

`endif

// ----- sv/des_pkg.sv -----
// DES constant tables (IP, FP, E, P, PC-1, PC-2, S-boxes, key shifts) and
// the fixed bit permutations built on them. No dependencies.
`default_nettype none

package des_pkg;

	localparam int unsigned ROUNDS = 16;

	localparam int unsigned T_IP [64] = '{
		58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
		62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
		57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
		61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

	localparam int unsigned T_FP [64] = '{
		40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
		38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
		36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
		34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

	localparam int unsigned T_E [48] = '{
		32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
		16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
		28,29,30,31,32,1};

	localparam int unsigned T_P [32] = '{
		16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
		2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};

	localparam int unsigned T_PC1 [56] = '{
		57,49,41,33,25,17,9, 1,58,50,42,34,26,18, 10,2,59,51,43,35,27,
		19,11,3,60,52,44,36, 63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
		14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

	localparam int unsigned T_PC2 [48] = '{
		14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
		41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
		46,42,50,36,29,32};

	// Total left rotation of C and D after each round (running sum of shifts)
	localparam int unsigned T_SHIFT_SUM [16] = '{
		1,2,4,6,8,10,12,14,15,17,19,21,23,25,27,28};

	localparam logic [3:0] T_SBOX [8][64] = '{
		'{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
		  4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
		'{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
		  0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
		'{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
		  13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
		'{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
		  10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
		'{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
		  4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
		'{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
		  9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
		'{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
		  1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
		'{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
		  7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

	// Table entries number bits from 1 at the most significant end.
	function automatic logic [63:0] des_ip(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[6'(63 - i)] = v[6'(64 - T_IP[i])];
		return r;
	endfunction

	function automatic logic [63:0] des_fp(input logic [63:0] v);
		logic [63:0] r;
		for (int i = 0; i < 64; i++) r[6'(63 - i)] = v[6'(64 - T_FP[i])];
		return r;
	endfunction

	function automatic logic [47:0] des_e(input logic [31:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[6'(47 - i)] = v[5'(32 - T_E[i])];
		return r;
	endfunction

	function automatic logic [31:0] des_p(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) r[5'(31 - i)] = v[5'(32 - T_P[i])];
		return r;
	endfunction

	function automatic logic [55:0] des_pc1(input logic [63:0] v);
		logic [55:0] r;
		for (int i = 0; i < 56; i++) r[6'(55 - i)] = v[6'(64 - T_PC1[i])];
		return r;
	endfunction

	function automatic logic [47:0] des_pc2(input logic [55:0] v);
		logic [47:0] r;
		for (int i = 0; i < 48; i++) r[6'(47 - i)] = v[6'(56 - T_PC2[i])];
		return r;
	endfunction

	// Rotate a 28-bit half left by a constant amount
	function automatic logic [27:0] des_rotl28(input logic [27:0] x, input int unsigned s);
		logic [55:0] w;
		w = {x, x} << s;
		return w[55:28];
	endfunction

	// Outer bits pick the row, inner four bits the column
	function automatic logic [3:0] des_sbox(input logic [2:0] n, input logic [5:0] six);
		return T_SBOX[n][{six[5], six[0], six[4:1]}];
	endfunction

endpackage

`default_nettype wire

// ----- sv/des_round.sv -----
// One DES Feistel round: expansion, key mix, eight S-boxes, P permutation.
// Depends on des_pkg for the tables and permutations.
`default_nettype none

module des_round (
	input  logic [31:0] l_in,
	input  logic [31:0] r_in,
	input  logic [47:0] rk,
	output logic [31:0] l_out,
	output logic [31:0] r_out
);
	import des_pkg::*;

	logic [47:0] mix;
	logic [31:0] sub;

	// Expand the right half and mix in the round key
	assign mix = des_e(r_in) ^ rk;

	// Substitute each 6-bit group through its S-box
	for (genvar j = 0; j < 8; j++) begin : g_sbox
		assign sub[31 - 4*j -: 4] = des_sbox(3'(j), mix[47 - 6*j -: 6]);
	end

	// Swap halves and fold the round function into the left half
	assign l_out = r_in;
	assign r_out = l_in ^ des_p(sub);

endmodule

`default_nettype wire

// ----- sv/des_block_cipher_core.sv -----
// DES ECB cipher core: input register, sixteen rounds, result register.
// Depends on des_pkg and des_round.
//
// Usage:
//   Write the 64-bit key with cfg_we/cipher_key while the core is idle; it
//   takes effect at once. The key resets to all zeros; parity bits are ignored.
//   Input beats carry block_in and mode (0 encrypt, 1 decrypt) on a
//   valid/ready channel; result beats carry block_out on a valid/ready channel.
//   Path: an accepted beat waits in the input register and moves into the
//   result register, which drives block_out, once that register is free.
//   Throughput: one block per cycle unless out_ready stalls; all sixteen rounds
//   sit in the single combinational path from the input register to the result
//   register, and the round keys are fixed wiring of the key register.
//   Stall: when out_ready is low the result register holds its beat and the
//   input register can still take one more block; in_ready drops only when
//   both registers are full and out_ready is low.
//   Reset: arst_n clears both valid flags and the key; no beat is in flight.
`default_nettype none

module des_block_cipher_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cipher_key,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        mode,
	input  logic [63:0] block_in,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [63:0] block_out
);
	import des_pkg::*;

	logic [63:0] key_q;
	logic        valid_s1;
	logic        mode_s1;
	logic [63:0] block_s1;
	logic        valid_s2;
	logic [63:0] block_s2;
	logic        adv_s2;

	logic [55:0] cd0;
	logic [47:0] rk     [ROUNDS];
	logic [47:0] rk_sel [ROUNDS];
	logic [31:0] l_w    [ROUNDS + 1];
	logic [31:0] r_w    [ROUNDS + 1];
	logic [63:0] ip_w;
	logic [63:0] result;

	// Hold the key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			key_q <= cipher_key;
		end
	end

	// Derive round keys: PC-1, cumulative rotations, PC-2 (wiring only)
	assign cd0 = des_pc1(key_q);
	for (genvar i = 0; i < ROUNDS; i++) begin : g_key
		assign rk[i] = des_pc2({des_rotl28(cd0[55:28], T_SHIFT_SUM[i]),
		                        des_rotl28(cd0[27:0],  T_SHIFT_SUM[i])});
		assign rk_sel[i] = mode_s1 ? rk[ROUNDS - 1 - i] : rk[i];
	end

	// Advance control: result register frees when empty or taken
	assign adv_s2   = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || adv_s2;

	// Capture the input beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mode_s1  <= mode;
			block_s1 <= block_in;
		end
	end

	// Run the initial permutation and sixteen rounds
	assign ip_w   = des_ip(block_s1);
	assign l_w[0] = ip_w[63:32];
	assign r_w[0] = ip_w[31:0];

	for (genvar i = 0; i < ROUNDS; i++) begin : g_round
		des_round u_round (
			.l_in (l_w[i]),
			.r_in (r_w[i]),
			.rk   (rk_sel[i]),
			.l_out(l_w[i + 1]),
			.r_out(r_w[i + 1])
		);
	end

	// Swap the halves and apply the inverse permutation
	assign result = des_fp({r_w[ROUNDS], l_w[ROUNDS]});

	// Load the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			block_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign block_out = block_s2;

endmodule

`default_nettype wire

// ----- sv/des_chk.sv -----
// Port-level checker for des_block_cipher_core, bound to the top level.
// Depends on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module des_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] block_out
);

	// A stalled result beat holds its value
	`DES_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(block_out), "result beat changed while stalled")

	// A ready receiver never backpressures the input
	`DES_ASSERT_IMPLY(a_ready_pass, clk, arst_n, out_ready, in_ready, "in_ready low with out_ready high")

	// Input stalls only when a result waits to be taken
	`DES_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, out_valid && !out_ready, "in_ready low without output stall")

	// An accepted block reaches the output when the result channel is not stalled
	`DES_ASSERT(a_latency, clk, arst_n, in_valid && in_ready ##1 out_ready |=> out_valid, "accepted block did not reach the output")

endmodule

bind des_block_cipher_core des_chk u_des_chk (.*);

`default_nettype wire

// ----- tb/sv/tb_des_block_cipher_core.sv -----
// Self-checking testbench for des_block_cipher_core: known-answer DES vectors,
// then random ECB traffic under three idle/stall patterns, checked per block.
// Depends on des_pkg (round tables) and the des_block_cipher_core RTL.

module tb_des_block_cipher_core;
	timeunit 1ns;
	timeprecision 1ps;

	import des_pkg::*;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned BLOCKS_PER_KEY = 100;
	localparam int unsigned KEYS_PER_PHASE = 5;
	localparam int unsigned SHOWN_ERRORS = 64;

	// One directed beat; answer is used only when known is set
	typedef struct packed {
		logic [63:0] key;
		logic        dec;
		logic [63:0] blk;
		logic        known;
		logic [63:0] answer;
	} kat_row_t;

	// One block in flight: what went in and what must come out
	typedef struct packed {
		logic [63:0] key;
		logic        dec;
		logic [63:0] blk;
		logic [63:0] want;
	} block_due_t;

	localparam kat_row_t KAT_ROWS [20] = '{
		// reset key, never written
		'{64'h0, MODE_ENC, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7},
		'{64'h0, MODE_DEC, 64'h8CA64DE9C1B123A7, 1'b1, 64'h0},
		'{64'h0, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
		'{64'h0, MODE_DEC, 64'hFFFFFFFFFFFFFFFF, 1'b0, 64'h0},
		// parity bits alone set: same schedule as the zero key
		'{64'h0101010101010101, MODE_ENC, 64'h0, 1'b1, 64'h8CA64DE9C1B123A7},
		'{64'h0101010101010101, MODE_DEC, 64'h8CA64DE9C1B123A7, 1'b1, 64'h0},
		'{64'hFFFFFFFFFFFFFFFF, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
		'{64'hFFFFFFFFFFFFFFFF, MODE_DEC, 64'h7359B2163E4EDC58, 1'b1, 64'hFFFFFFFFFFFFFFFF},
		// parity bits cleared: same schedule as the all-ones key
		'{64'hFEFEFEFEFEFEFEFE, MODE_ENC, 64'hFFFFFFFFFFFFFFFF, 1'b1, 64'h7359B2163E4EDC58},
		'{64'hFEFEFEFEFEFEFEFE, MODE_ENC, 64'h0, 1'b0, 64'h0},
		'{64'h133457799BBCDFF1, MODE_ENC, 64'h0123456789ABCDEF, 1'b1, 64'h85E813540F0AB405},
		'{64'h133457799BBCDFF1, MODE_DEC, 64'h85E813540F0AB405, 1'b1, 64'h0123456789ABCDEF},
		'{64'h0E329232EA6D0D73, MODE_ENC, 64'h8787878787878787, 1'b1, 64'h0},
		'{64'h0E329232EA6D0D73, MODE_DEC, 64'h0, 1'b1, 64'h8787878787878787},
		'{64'h0123456789ABCDEF, MODE_ENC, 64'h4E6F772069732074, 1'b1, 64'h3FA40E8A984D4815},
		'{64'h0123456789ABCDEF, MODE_DEC, 64'h3FA40E8A984D4815, 1'b1, 64'h4E6F772069732074},
		'{64'h8000000000000000, MODE_ENC, 64'h0000000000000001, 1'b0, 64'h0},
		'{64'h8000000000000000, MODE_DEC, 64'h8000000000000000, 1'b0, 64'h0},
		'{64'hAAAAAAAAAAAAAAAA, MODE_ENC, 64'h5555555555555555, 1'b0, 64'h0},
		'{64'h5555555555555555, MODE_DEC, 64'hAAAAAAAAAAAAAAAA, 1'b0, 64'h0}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cipher_key = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        mode = MODE_ENC;
	logic [63:0] block_in = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [63:0] block_out;

	block_due_t  expected_blocks [$];
	logic [63:0] active_key = '0;
	int unsigned src_gap_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned cycle_count = 0;
	int unsigned n_errors = 0;
	int unsigned n_checked = 0;
	int unsigned n_sent = 0;
	int unsigned n_dec = 0;
	int unsigned n_keys = 0;

	des_block_cipher_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cipher_key(cipher_key),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.block_in  (block_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.block_out (block_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Full DES on one block: key schedule, IP, sixteen Feistel rounds, swap, FP
	function automatic logic [63:0] des_crypt(input logic [63:0] key, input logic dec,
			input logic [63:0] blk);
		logic [55:0] cd;
		logic [27:0] c, d;
		logic [47:0] subkey [16];
		logic [63:0] perm, res;
		logic [31:0] lh, rh, sbox_out, f_out, tmp;
		logic [47:0] ex;
		logic [5:0]  six;
		int unsigned step, k;
		for (int i = 0; i < 56; i++) cd[55 - i] = key[64 - T_PC1[i]];
		c = cd[55:28];
		d = cd[27:0];
		// rotate both halves; rounds 1, 2, 9 and 16 shift by one, the rest by two
		for (int r = 0; r < 16; r++) begin
			step = (r == 0 || r == 1 || r == 8 || r == 15) ? 1 : 2;
			repeat (step) begin
				c = {c[26:0], c[27]};
				d = {d[26:0], d[27]};
			end
			cd = {c, d};
			for (int j = 0; j < 48; j++) subkey[r][47 - j] = cd[56 - T_PC2[j]];
		end
		for (int i = 0; i < 64; i++) perm[63 - i] = blk[64 - T_IP[i]];
		lh = perm[63:32];
		rh = perm[31:0];
		for (int r = 0; r < 16; r++) begin
			k = dec ? 15 - r : r;
			for (int j = 0; j < 48; j++) ex[47 - j] = rh[32 - T_E[j]];
			ex = ex ^ subkey[k];
			for (int b = 0; b < 8; b++) begin
				six = ex[47 - 6 * b -: 6];
				sbox_out[31 - 4 * b -: 4] = T_SBOX[b][{six[5], six[0], six[4:1]}];
			end
			for (int j = 0; j < 32; j++) f_out[31 - j] = sbox_out[32 - T_P[j]];
			tmp = lh ^ f_out;
			lh = rh;
			rh = tmp;
		end
		perm = {rh, lh};
		for (int i = 0; i < 64; i++) res[63 - i] = perm[64 - T_FP[i]];
		return res;
	endfunction

	// Mostly random keys, now and then a weak or extreme one
	function automatic logic [63:0] pick_key();
		case ($urandom_range(9))
			0: return 64'h0;
			1: return 64'hFFFFFFFFFFFFFFFF;
			2: return 64'h0101010101010101;
			3: return 64'hE0E0E0E0F1F1F1F1;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Drop valid, wait for the pipe to empty, then write the key
	task automatic load_key(input logic [63:0] k);
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cipher_key <= k;
		@(posedge clk);
		cfg_we <= 1'b0;
		active_key = k;
		n_keys++;
	endtask

	// Offer one input beat after a random gap; record its expected result
	task automatic send_block(input logic m, input logic [63:0] b, input logic known,
			input logic [63:0] answer);
		block_due_t due;
		while ($urandom_range(99) < src_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		block_in <= b;
		do @(posedge clk); while (!in_ready);
		due.key = active_key;
		due.dec = m;
		due.blk = b;
		due.want = known ? answer : des_crypt(active_key, m, b);
		expected_blocks.push_back(due);
		n_sent++;
		if (m == MODE_DEC) n_dec++;
	endtask

	// Stall the result channel at random
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		block_due_t due;
		if (arst_n && out_valid && out_ready) begin
			if (expected_blocks.size() == 0) begin
				n_errors++;
				$display("%0t: unexpected result beat block_out=%h", $time, block_out);
			end else begin
				due = expected_blocks.pop_front();
				n_checked++;
				if (block_out !== due.want) begin
					n_errors++;
					if (n_errors <= SHOWN_ERRORS)
						$display("%0t: block_out mismatch key=%h mode=%0d in=%h expected %h actual %h",
							$time, due.key, due.dec, due.blk, due.want, block_out);
					else if (n_errors == SHOWN_ERRORS + 1)
						$display("%0t: further mismatches not shown", $time);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				expected_blocks.size());
			$display("** des_block_cipher_core: FAILED **");
			$finish;
		end
	end

	initial begin
		logic        m, prev_m;
		logic [63:0] b, prev_res;
		prev_m = MODE_ENC;
		prev_res = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// known-answer and corner vectors
		src_gap_pct = 25;
		sink_stall_pct = 47;
		for (int i = 0; i < $size(KAT_ROWS); i++) begin
			if (KAT_ROWS[i].key !== active_key) load_key(KAT_ROWS[i].key);
			send_block(KAT_ROWS[i].dec, KAT_ROWS[i].blk, KAT_ROWS[i].known,
				KAT_ROWS[i].answer);
		end

		// random traffic: sink-stall heavy, sender-idle heavy, then full rate
		for (int ph = 0; ph < 3; ph++) begin
			src_gap_pct = (ph == 0) ? 25 : (ph == 1) ? 47 : 0;
			sink_stall_pct = (ph == 0) ? 47 : (ph == 1) ? 25 : 0;
			for (int kk = 0; kk < KEYS_PER_PHASE; kk++) begin
				load_key(pick_key());
				prev_res = {$urandom, $urandom};
				for (int n = 0; n < BLOCKS_PER_KEY; n++) begin
					// a quarter of the beats feed the last result back the other way
					if ($urandom_range(3) == 0) begin
						m = !prev_m;
						b = prev_res;
					end else begin
						m = $urandom_range(1);
						b = {$urandom, $urandom};
					end
					send_block(m, b, 1'b0, '0);
					prev_m = m;
					prev_res = expected_blocks[$].want;
				end
			end
		end

		// drain, then wait for any stray beat
		in_valid <= 1'b0;
		sink_stall_pct = 0;
		while (expected_blocks.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);

		$display("Run covered %0d blocks (%0d decrypt) under %0d key loads;",
			n_sent, n_dec, n_keys);
		$display("%0d result beats checked, %0d errors.", n_checked, n_errors);
		if (n_errors == 0)
			$display("** des_block_cipher_core: PASSED **");
		else
			$display("** des_block_cipher_core: FAILED **");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+sv
sv/des_pkg.sv
sv/des_round.sv
sv/des_block_cipher_core.sv
sv/des_chk.sv
tb/sv/tb_des_block_cipher_core.sv
